// ===== sv/rcf_pkg.sv =====
package rcf_pkg;

    // Texture store geometry
    localparam int TEX_SIZE      = 64;
    localparam int TEX_BITS      = $clog2(TEX_SIZE);
    localparam int TEXTURE_COUNT = 4;
    localparam int TEXNUM_W      = $clog2(TEXTURE_COUNT);
    localparam int STORE_DEPTH   = TEXTURE_COUNT * TEX_SIZE * TEX_SIZE;
    localparam int STORE_AW      = $clog2(STORE_DEPTH);

    // Field widths
    localparam int COLOUR_W = 24;
    localparam int ROW_W    = 9;
    localparam int COL_W    = 12;
    localparam int LH_W     = 16;
    localparam int ADDR_W   = 14;

    // Fixed-point walk
    localparam int FRAC_W = 16;
    localparam int STEP_W = 24;
    localparam int POS_W  = 40;
    localparam int OFS_W  = 18;

    // Step divider: dividend is TEX_SIZE with FRAC_W fraction bits
    localparam int DIV_W     = TEX_BITS + FRAC_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam logic [DIV_W-1:0] DIVIDEND = DIV_W'(TEX_SIZE * (1 << FRAC_W));

    // Halve each channel of a shaded texel
    localparam logic [COLOUR_W-1:0] SHADE_MASK = 24'h7F7F7F;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Request kinds
    localparam logic REQ_TEXEL = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    // Configuration register indexes
    localparam logic REG_CEILING = 1'b0;
    localparam logic REG_FLOOR   = 1'b1;

    // Texture numbers
    localparam logic [TEXNUM_W-1:0] TEX_XPOS = 2'd0;
    localparam logic [TEXNUM_W-1:0] TEX_XNEG = 2'd1;
    localparam logic [TEXNUM_W-1:0] TEX_YPOS = 2'd2;
    localparam logic [TEXNUM_W-1:0] TEX_YNEG = 2'd3;

    // Row class of a pixel
    typedef enum logic [1:0] {
        CLS_CEILING = 2'd0,
        CLS_FLOOR   = 2'd1,
        CLS_WALL    = 2'd2
    } t_cls;

    typedef struct packed {
        logic                    req_type;
        logic [ADDR_W-1:0]       texel_address;
        logic [COLOUR_W-1:0]     texel_value;
        logic [COL_W-1:0]        column;
        logic [ROW_W-1:0]        wall_top;
        logic [ROW_W-1:0]        floor_top;
        logic [LH_W-1:0]         wall_height;
        logic [TEX_BITS-1:0]     tex_x;
        logic                    side;
        logic                    dir_x_positive;
        logic                    dir_y_positive;
    } t_in;

    typedef struct packed {
        logic [COLOUR_W-1:0] colour;
        logic [ROW_W-1:0]    row;
        logic [COL_W-1:0]    out_column;
        logic                last_of_column;
    } t_out;

    // Classified command as queued for the back end
    typedef struct packed {
        logic                    req_type;
        logic                    first;
        t_cls                    cls;
        logic [TEXNUM_W-1:0]     tex_num;
        logic [TEX_BITS-1:0]     tex_x;
        logic                    side;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        column;
        logic                    last;
        logic [LH_W-1:0]         lh;
        logic [OFS_W-1:0]        offset;
        logic [STORE_AW-1:0]     waddr;
        logic [COLOUR_W-1:0]     wdata;
    } t_cmd;

endpackage

// ===== sv/rcf_front.sv =====
module rcf_front
    import rcf_pkg::*;
#(
    parameter int SCREEN_ROWS = 480
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    input  logic i_full,
    output logic o_push,
    output t_cmd o_cmd
);

    localparam int RW = $clog2(SCREEN_ROWS);
    localparam int CW = (RW > ROW_W) ? RW : ROW_W;

    logic [RW-1:0]    r_row;
    logic [RW-1:0]    n_row;
    logic             is_pixel;
    logic             is_last;
    logic [LH_W-1:0]  lh;
    logic [OFS_W-1:0] offset;
    logic [CW-1:0]    row_cmp;
    t_cls             cls;

    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full;
    assign is_pixel   = (i_in_data.req_type == REQ_PIXEL);
    assign is_last    = (r_row == RW'(SCREEN_ROWS - 1));
    assign row_cmp    = CW'(r_row);

    // Clamp zero line height, form start offset of the texture walk
    assign lh     = (i_in_data.wall_height == '0) ? LH_W'(1) : i_in_data.wall_height;
    assign offset = OFS_W'(i_in_data.wall_top) - OFS_W'(SCREEN_ROWS / 2)
                  + OFS_W'(lh[LH_W-1:1]);

    // Classify the row: floor wins over ceiling
    always_comb begin
        if (row_cmp >= CW'(i_in_data.floor_top)) begin
            cls = CLS_FLOOR;
        end else if (row_cmp < CW'(i_in_data.wall_top)) begin
            cls = CLS_CEILING;
        end else begin
            cls = CLS_WALL;
        end
    end

    // Build the queued command
    always_comb begin
        o_cmd.req_type = i_in_data.req_type;
        o_cmd.first    = (r_row == '0);
        o_cmd.cls      = cls;
        if (i_in_data.side) begin
            o_cmd.tex_num = i_in_data.dir_y_positive ? TEX_YPOS : TEX_YNEG;
        end else begin
            o_cmd.tex_num = i_in_data.dir_x_positive ? TEX_XPOS : TEX_XNEG;
        end
        o_cmd.tex_x    = i_in_data.tex_x;
        o_cmd.side     = i_in_data.side;
        o_cmd.row      = ROW_W'(r_row);
        o_cmd.column   = i_in_data.column;
        o_cmd.last     = is_last;
        o_cmd.lh       = lh;
        o_cmd.offset   = offset;
        o_cmd.waddr    = i_in_data.texel_address[STORE_AW-1:0];
        o_cmd.wdata    = i_in_data.texel_value;
    end

    // Advance the row walk on each pixel transfer, wrap at column end
    always_comb begin
        n_row = r_row;
        if (o_push && is_pixel) begin
            n_row = is_last ? '0 : r_row + RW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else begin
            r_row <= n_row;
        end
    end

endmodule

// ===== sv/rcf_queue.sv =====
module rcf_queue
    import rcf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_head
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];

    // Store entries; depth is a power of two so pointers wrap on their own
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

endmodule

// ===== sv/rcf_back.sv =====
module rcf_back
    import rcf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  t_cmd                i_q_head,
    output logic                o_q_pop,
    input  logic [COLOUR_W-1:0] i_ceiling,
    input  logic [COLOUR_W-1:0] i_floor,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out                o_out_data
);

    typedef enum logic [2:0] {
        S_RUN = 3'b001,
        S_DIV = 3'b010,
        S_MUL = 3'b100
    } t_bstate;

    typedef struct packed {
        t_cls             cls;
        logic             side;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] column;
        logic             last;
    } t_bstage;

    t_bstate r_state;
    t_bstate n_state;

    logic                r_primed;
    logic [STEP_W-1:0]   r_step;
    logic [POS_W-1:0]    r_pos;

    // Step divider
    logic [LH_W-1:0]      r_rem;
    logic [DIV_W-1:0]     r_dvd;
    logic [DIV_W-1:0]     r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [LH_W:0]        trial;
    logic                 trial_ge;
    logic                 div_done;

    logic signed [OFS_W+STEP_W:0] prod;

    // Texture store
    logic [COLOUR_W-1:0] r_tex [STORE_DEPTH];
    logic [COLOUR_W-1:0] r_rdata;
    logic [STORE_AW-1:0] raddr;

    // Sample stage and output register
    logic                r_b_valid;
    t_bstage             r_b;
    logic                r_o_valid;
    t_out                r_o;
    logic                out_free;
    logic                b_adv;
    logic                head_pixel;
    logic                head_ready;
    logic                pop_write;
    logic                pop_pixel;
    logic                pop_wall;
    logic [COLOUR_W-1:0] colour;

    assign head_pixel = (i_q_head.req_type == REQ_PIXEL);
    assign head_ready = !i_q_head.first || r_primed;
    assign out_free   = !r_o_valid || i_out_ready;
    assign b_adv      = !r_b_valid || out_free;

    assign pop_write = (r_state == S_RUN) && i_q_valid && !head_pixel;
    assign pop_pixel = (r_state == S_RUN) && i_q_valid && head_pixel && head_ready && b_adv;
    assign pop_wall  = pop_pixel && (i_q_head.cls == CLS_WALL);
    assign o_q_pop   = pop_write || pop_pixel;

    assign trial    = {r_rem, r_dvd[DIV_W-1]};
    assign trial_ge = (trial >= {1'b0, i_q_head.lh});
    assign div_done = (r_cnt == DIV_CNT_W'(DIV_W - 1));
    assign prod     = $signed(i_q_head.offset) * $signed({1'b0, STEP_W'(r_quo)});

    assign raddr = {i_q_head.tex_num, r_pos[FRAC_W+TEX_BITS-1:FRAC_W], i_q_head.tex_x};

    // Sequence: run, or work out step and start position for a new column
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_RUN: begin
                if (i_q_valid && head_pixel && !head_ready) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_RUN;
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_RUN;
            r_primed <= 1'b0;
            r_step   <= '0;
            r_pos    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_MUL) begin
                r_primed <= 1'b1;
                r_step   <= STEP_W'(r_quo);
                r_pos    <= prod[POS_W-1:0];
            end else if (pop_pixel) begin
                r_primed <= 1'b0;
                if (pop_wall) begin
                    r_pos <= r_pos + POS_W'(r_step);
                end
            end
        end
    end

    // Restoring divider, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (r_state == S_RUN) begin
            r_rem <= '0;
            r_dvd <= DIVIDEND;
            r_quo <= '0;
            r_cnt <= '0;
        end else if (r_state == S_DIV) begin
            r_rem <= trial_ge ? LH_W'(trial - {1'b0, i_q_head.lh}) : trial[LH_W-1:0];
            r_dvd <= {r_dvd[DIV_W-2:0], 1'b0};
            r_quo <= {r_quo[DIV_W-2:0], trial_ge};
            r_cnt <= r_cnt + DIV_CNT_W'(1);
        end
    end

    // Texture store: write on texel transfer, registered read on wall rows
    always_ff @(posedge i_clk) begin
        if (pop_write) begin
            r_tex[i_q_head.waddr] <= i_q_head.wdata;
        end
        if (pop_wall) begin
            r_rdata <= r_tex[raddr];
        end
    end

    // Pick the pixel colour
    always_comb begin
        unique case (r_b.cls)
            CLS_FLOOR:   colour = i_floor;
            CLS_WALL:    colour = r_b.side ? ((r_rdata >> 1) & SHADE_MASK) : r_rdata;
            default:     colour = i_ceiling;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pop_pixel) begin
            r_b.cls    <= i_q_head.cls;
            r_b.side   <= i_q_head.side;
            r_b.row    <= i_q_head.row;
            r_b.column <= i_q_head.column;
            r_b.last   <= i_q_head.last;
        end
        if (r_b_valid && out_free) begin
            r_o.colour         <= colour;
            r_o.row            <= r_b.row;
            r_o.out_column     <= r_b.column;
            r_o.last_of_column <= r_b.last;
        end
    end

    // Hold results until transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (pop_pixel) begin
                r_b_valid <= 1'b1;
            end else if (out_free) begin
                r_b_valid <= 1'b0;
            end
            if (r_b_valid && out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o;

endmodule

// ===== sv/raycast_textured_column_fill_top.sv =====
// Channel  | Handshake                 | Payload
// ---------+---------------------------+--------------------------------
// input    | i_in_valid / o_in_ready   | i_in_data  (t_in)
// output   | o_out_valid / i_out_ready | o_out_data (t_out)
// config   | i_cfg_wr_en               | i_cfg_idx, i_cfg_wdata
//
// Texel writes and pixel rows 1 and on issue back to back, pixel rows only while
// the output is not stalled. Row 0 of a column waits at the queue head while the
// step divider forms DIV_W (23) quotient bits and the start position is multiplied
// out. A pixel row, wall or not, passes the sample stage and the output register.
// Reset is synchronous, active low; the texture store is not cleared.
// A four-entry queue and an output register let input and output stall apart.
module raycast_textured_column_fill_top
    import rcf_pkg::*;
#(
    parameter int SCREEN_ROWS = 480
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in                 i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out                o_out_data,
    input  logic                i_cfg_wr_en,
    input  logic                i_cfg_idx,
    input  logic [COLOUR_W-1:0] i_cfg_wdata
);

    logic                q_push;
    logic                q_full;
    logic                q_pop;
    logic                q_valid;
    t_cmd                q_cmd;
    t_cmd                q_head;
    logic [COLOUR_W-1:0] r_ceiling;
    logic [COLOUR_W-1:0] r_floor;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ceiling <= '0;
            r_floor   <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                REG_CEILING: r_ceiling <= i_cfg_wdata;
                REG_FLOOR:   r_floor   <= i_cfg_wdata;
                default:     r_ceiling <= r_ceiling;
            endcase
        end
    end

    rcf_front #(
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_full     (q_full),
        .o_push     (q_push),
        .o_cmd      (q_cmd)
    );

    rcf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    rcf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_head    (q_head),
        .o_q_pop     (q_pop),
        .i_ceiling   (r_ceiling),
        .i_floor     (r_floor),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

`ifndef ASSERT_OFF
    // Never pop an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    // Head entry holds until it is popped
    a_head_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_valid && !q_pop) |=> (q_valid && $stable(q_head)))
        else $error("queue head changed without pop");

    // Column end flag only on the bottom row
    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.last_of_column)
            |-> (o_out_data.row == ROW_W'(SCREEN_ROWS - 1)))
        else $error("last_of_column on wrong row");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import rcf_pkg::*;

    localparam int SCREEN_ROWS  = 480;
    localparam int ITEMS        = 1500;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = DIV_W + 16;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 300;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    t_in                 in_data   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    t_out                out_data;
    logic                cfg_we    = 1'b0;
    logic                cfg_idx   = REG_CEILING;
    logic [COLOUR_W-1:0] cfg_wd    = '0;

    // Items waiting to be offered, and the pixels they should produce
    t_in  item_q[$];
    t_out pixel_q[$];

    // Predicted block state: texture store, column walk and colours
    logic [COLOUR_W-1:0] texels[STORE_DEPTH];
    bit                  texel_known[STORE_DEPTH];
    logic [ROW_W-1:0]    walk_row  = '0;
    logic [STEP_W-1:0]   walk_step = '0;
    logic [POS_W-1:0]    walk_pos  = '0;
    logic [COLOUR_W-1:0] ceil_rgb  = '0;
    logic [COLOUR_W-1:0] floor_rgb = '0;

    t_in shape;
    bit  column_done  = 1'b0;
    int  random_items = 0;
    int  err_cnt      = 0;
    int  results_seen = 0;

    int  tx_wait   = 0;
    bit  tx_calm   = 1'b0;
    int  rx_wait   = 0;
    bit  rx_calm   = 1'b0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    raycast_textured_column_fill_top #(
        .SCREEN_ROWS(SCREEN_ROWS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .i_cfg_wr_en(cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_wdata(cfg_wd)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [TEXNUM_W-1:0] pick_texture(input t_in it);
        if (!it.side) return it.dir_x_positive ? TEX_XPOS : TEX_XNEG;
        return it.dir_y_positive ? TEX_YPOS : TEX_YNEG;
    endfunction

    // Texel write with every unused field filled with noise
    function automatic t_in texel_item(input logic [ADDR_W-1:0] a,
                                       input logic [COLOUR_W-1:0] v);
        t_in        it;
        logic [95:0] junk;
        junk = {$urandom, $urandom, $urandom};
        it = junk[$bits(t_in)-1:0];
        it.req_type      = REQ_TEXEL;
        it.texel_address = a;
        it.texel_value   = v;
        return it;
    endfunction

    function automatic t_in pixel_item(input int col, input int ds, input int de,
                                       input int lh, input int tx, input int sd,
                                       input int dx, input int dy);
        t_in it;
        it.req_type       = REQ_PIXEL;
        it.texel_address  = ADDR_W'($urandom);
        it.texel_value    = COLOUR_W'($urandom);
        it.column         = COL_W'(col);
        it.wall_top       = ROW_W'(ds);
        it.floor_top      = ROW_W'(de);
        it.wall_height    = LH_W'(lh);
        it.tex_x          = TEX_BITS'(tx);
        it.side           = sd[0];
        it.dir_x_positive = dx[0];
        it.dir_y_positive = dy[0];
        return it;
    endfunction

    // Queue one item and predict the pixel it produces; a wall row that would
    // read a texel not yet written gets a write to that texel just ahead of it
    task automatic plan_item(input t_in it);
        t_cls                cls;
        t_out                px;
        t_in                 fill;
        logic [ADDR_W-1:0]   a;
        logic [COLOUR_W-1:0] rgb;
        logic [63:0]         quo;
        int unsigned         lh;
        longint              ofs;
        if (it.req_type == REQ_TEXEL) begin
            texels[it.texel_address]      = it.texel_value;
            texel_known[it.texel_address] = 1'b1;
            item_q.push_back(it);
        end else begin
            // latch step and start position on the first row of a column
            if (walk_row == 0) begin
                lh  = (it.wall_height == 0) ? 1 : it.wall_height;
                quo = (64'(TEX_SIZE) << FRAC_W) / 64'(lh);
                if (quo > 64'hFF_FFFF) quo = 64'hFF_FFFF;
                walk_step = quo[STEP_W-1:0];
                ofs = longint'(it.wall_top) - longint'(SCREEN_ROWS / 2) + longint'(lh / 2);
                walk_pos = POS_W'(ofs * longint'(walk_step));
            end
            if (walk_row >= it.floor_top) cls = CLS_FLOOR;
            else if (walk_row < it.wall_top) cls = CLS_CEILING;
            else cls = CLS_WALL;
            case (cls)
                CLS_FLOOR: rgb = floor_rgb;
                CLS_CEILING: rgb = ceil_rgb;
                default: begin
                    a = {pick_texture(it), walk_pos[FRAC_W +: TEX_BITS], it.tex_x};
                    if (!texel_known[a]) begin
                        fill = texel_item(a, COLOUR_W'($urandom));
                        texels[a]      = fill.texel_value;
                        texel_known[a] = 1'b1;
                        item_q.push_back(fill);
                    end
                    rgb      = texels[a];
                    walk_pos = walk_pos + POS_W'(walk_step);
                    if (it.side) rgb = (rgb >> 1) & SHADE_MASK;
                end
            endcase
            px.colour         = rgb;
            px.row            = walk_row;
            px.out_column     = it.column;
            px.last_of_column = (walk_row == SCREEN_ROWS - 1);
            pixel_q.push_back(px);
            item_q.push_back(it);
            if (walk_row == SCREEN_ROWS - 1) begin
                walk_row    = '0;
                column_done = 1'b1;
            end else begin
                walk_row = walk_row + 1'b1;
            end
        end
    endtask

    // Pick the wall geometry of a new column, mostly centred as a raycaster would
    task automatic new_shape(input int phase);
        int unsigned lh;
        int unsigned half;
        int          ds;
        int          de;
        case (phase)
            1: lh = 65535;
            2: lh = $urandom_range(1, 64);
            default: begin
                case ($urandom_range(0, 3))
                    0: lh = $urandom_range(1, 8);
                    1: lh = $urandom_range(65, 1000);
                    2: lh = $urandom_range(1, 480);
                    default: lh = $urandom_range(1, 65535);
                endcase
            end
        endcase
        half = lh / 2;
        ds = (half >= SCREEN_ROWS / 2) ? 0 : SCREEN_ROWS / 2 - half;
        de = (half >= SCREEN_ROWS / 2) ? SCREEN_ROWS : SCREEN_ROWS / 2 + half;
        if ($urandom_range(0, 3) == 0) begin
            ds = $urandom_range(0, 479);
            de = $urandom_range(0, 480);
        end
        shape = pixel_item($urandom, ds, de, lh, $urandom, $urandom, $urandom, $urandom);
    endtask

    // One random item: mostly the next row of the column, sometimes a texel write
    task automatic random_step();
        t_in                 it;
        logic [ADDR_W-1:0]   a;
        logic [COLOUR_W-1:0] v;
        case ($urandom_range(0, 3))
            0: v = '0;
            1: v = '1;
            default: v = COLOUR_W'($urandom);
        endcase
        if ($urandom_range(0, 7) == 0) begin
            a = ADDR_W'($urandom);
            if ($urandom_range(0, 1) == 1)
                a = {pick_texture(shape), TEX_BITS'($urandom), shape.tex_x};
            plan_item(texel_item(a, v));
        end else begin
            it = shape;
            it.texel_address = ADDR_W'($urandom);
            it.texel_value   = v;
            if ($urandom_range(0, 9) == 0) begin
                it.wall_top    = ROW_W'($urandom_range(0, 479));
                it.floor_top   = ROW_W'($urandom_range(0, 480));
                it.wall_height = LH_W'($urandom);
            end
            if ($urandom_range(0, 9) == 0) begin
                it.tex_x          = TEX_BITS'($urandom);
                it.side           = 1'($urandom);
                it.dir_x_positive = 1'($urandom);
                it.dir_y_positive = 1'($urandom);
            end
            if ($urandom_range(0, 19) == 0) it.column = COL_W'($urandom);
            plan_item(it);
        end
        random_items++;
    endtask

    // Extremes, every texture choice and the row class corner cases
    task automatic directed();
        plan_item(texel_item('0, '1));
        plan_item(texel_item('1, '0));
        // first row with zero line height, treated as one
        plan_item(pixel_item(0, 0, 480, 0, 0, 0, 1, 0));
        plan_item(pixel_item(4095, 5, 480, 65535, 63, 0, 0, 0));
        plan_item(pixel_item(4095, 0, 0, 1, 0, 1, 1, 1));
        // inverted geometry: floor wins over ceiling
        plan_item(pixel_item(4095, 400, 3, 1, 0, 0, 1, 0));
        plan_item(pixel_item(4095, 479, 480, 1, 63, 1, 0, 0));
        plan_item(pixel_item(12'h555, 0, 480, 64, 63, 0, 0, 1));
        plan_item(texel_item(14'h2AAA, 24'h555555));
        plan_item(pixel_item(12'hAAA, 0, 480, 64, 21, 1, 0, 1));
        plan_item(pixel_item(12'h555, 0, 480, 64, 42, 1, 1, 0));
        // single wall row, then the floor starting at or above the row
        plan_item(pixel_item(12'hAAA, 8, 9, 64, 5, 0, 1, 1));
        plan_item(pixel_item(12'hAAA, 10, 9, 64, 5, 0, 1, 1));
        plan_item(texel_item(14'h1555, 24'hAAAAAA));
        plan_item(pixel_item(12'h555, 10, 480, 0, 0, 0, 1, 0));
        plan_item(pixel_item(12'h555, 12, 12, 0, 0, 0, 1, 0));
    endtask

    // Wait until every item is taken and every pixel has come back
    task automatic settle();
        while (item_q.size() != 0 || in_valid || pixel_q.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic check_pixel(input t_out got);
        t_out want;
        if (pixel_q.size() == 0) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
                $display("unexpected pixel: colour %06h row %0d column %0d last %0b",
                         got.colour, got.row, got.out_column, got.last_of_column);
        end else begin
            want = pixel_q.pop_front();
            if (got.colour !== want.colour || got.row !== want.row ||
                got.out_column !== want.out_column ||
                got.last_of_column !== want.last_of_column) begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $display("pixel mismatch: expected colour %06h row %0d column %0d last %0b",
                             want.colour, want.row, want.out_column, want.last_of_column,
                             ", got colour %06h row %0d column %0d last %0b",
                             got.colour, got.row, got.out_column, got.last_of_column);
            end
        end
    endtask

    // Offer queued items, holding each until its transfer, with a drawn gap after it
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            tx_wait  <= 0;
        end else if (!in_valid || in_ready) begin
            if (tx_wait != 0) begin
                in_valid <= 1'b0;
                tx_wait  <= tx_wait - 1;
            end else if (item_q.size() != 0) begin
                in_data  <= item_q.pop_front();
                in_valid <= 1'b1;
                tx_wait  <= tx_calm ? 0 : $urandom_range(0, 5);
                if ($urandom_range(0, 39) == 0) tx_calm <= !tx_calm;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Take results, check each transfer, and stall for a drawn number of cycles
    always @(posedge clk) begin
        int w;
        if (!rst_n) begin
            out_ready <= 1'b0;
            rx_wait   <= 0;
        end else if (out_valid && out_ready) begin
            check_pixel(out_data);
            results_seen <= results_seen + 1;
            w = rx_calm ? 0 : $urandom_range(0, 5);
            if ($urandom_range(0, 39) == 0) rx_calm <= !rx_calm;
            rx_wait   <= w;
            out_ready <= (w == 0) && (hold_left == 0);
        end else if (hold_left != 0) begin
            out_ready <= 1'b0;
        end else if (rx_wait != 0) begin
            rx_wait   <= rx_wait - 1;
            out_ready <= (rx_wait == 1);
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Hold off the output once for a long stretch so the input backs up
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen == HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    initial begin : stimulus
        int                  phase;
        logic [COLOUR_W-1:0] c_rgb;
        logic [COLOUR_W-1:0] f_rgb;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        phase = 0;
        while (phase == 0 || random_items < ITEMS) begin
            if (phase != 0) settle();
            case (phase)
                0: begin
                    c_rgb = '1;
                    f_rgb = '0;
                end
                1: begin
                    c_rgb = '0;
                    f_rgb = '1;
                end
                default: begin
                    c_rgb = COLOUR_W'($urandom);
                    f_rgb = COLOUR_W'($urandom);
                end
            endcase
            // update both colours while the block is idle
            @(posedge clk);
            cfg_we  <= 1'b1;
            cfg_idx <= REG_CEILING;
            cfg_wd  <= c_rgb;
            ceil_rgb = c_rgb;
            @(posedge clk);
            cfg_idx <= REG_FLOOR;
            cfg_wd  <= f_rgb;
            floor_rgb = f_rgb;
            @(posedge clk);
            cfg_we <= 1'b0;
            @(negedge clk);
            column_done = 1'b0;
            if (phase == 0) directed();
            new_shape(phase);
            while (!column_done) random_step();
            phase++;
        end
        settle();
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
